[hdl/ilp_pkg.sv]
package ilp_pkg;

	// parse phase of the current string
	typedef enum logic [2:0] {
		PH_START = 3'd0,
		PH_ZERO  = 3'd1,
		PH_DEC   = 3'd2,
		PH_HEX   = 3'd3,
		PH_OCT   = 3'd4,
		PH_DONE  = 3'd5
	} phase_t;

	// parser state after one character
	typedef struct packed {
		phase_t      phase;
		logic [63:0] acc;
	} step_t;

	localparam int unsigned CHAR_W  = 8;
	localparam int unsigned VALUE_W = 64;

	// character codes
	localparam logic [CHAR_W-1:0] CH_0   = 8'h30;
	localparam logic [CHAR_W-1:0] CH_1   = 8'h31;
	localparam logic [CHAR_W-1:0] CH_7   = 8'h37;
	localparam logic [CHAR_W-1:0] CH_9   = 8'h39;
	localparam logic [CHAR_W-1:0] CH_UA  = 8'h41;
	localparam logic [CHAR_W-1:0] CH_UF  = 8'h46;
	localparam logic [CHAR_W-1:0] CH_UG  = 8'h47;
	localparam logic [CHAR_W-1:0] CH_UK  = 8'h4b;
	localparam logic [CHAR_W-1:0] CH_UM  = 8'h4d;
	localparam logic [CHAR_W-1:0] CH_UT  = 8'h54;
	localparam logic [CHAR_W-1:0] CH_UX  = 8'h58;
	localparam logic [CHAR_W-1:0] CH_LA  = 8'h61;
	localparam logic [CHAR_W-1:0] CH_LF  = 8'h66;
	localparam logic [CHAR_W-1:0] CH_LG  = 8'h67;
	localparam logic [CHAR_W-1:0] CH_LK  = 8'h6b;
	localparam logic [CHAR_W-1:0] CH_LM  = 8'h6d;
	localparam logic [CHAR_W-1:0] CH_LT  = 8'h74;
	localparam logic [CHAR_W-1:0] CH_LX  = 8'h78;

endpackage

[hdl/integer_literal_parser.sv]
// Parses one numeric string, one ASCII character per input transaction, with
// tlast on the final character, and returns one 64-bit value on that final
// character. A leading 1-9 selects decimal, 0x or 0X hex, any other leading
// 0 octal, anything else gives 0. A decimal K, M, G or T suffix (either case)
// shifts left by 10, 20, 30 or 40. The first character outside the radix
// ends the number; the rest of the string is ignored. Values wrap modulo
// 2^64. One character is taken every cycle unless the input stalls: the
// character goes into an input register, the phase and accumulator update
// from it, and the value lands in the output register as the last character
// leaves the input register. The input stalls only while a finished value
// waits at the output and the registered character is also a last one.
module integer_literal_parser (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // char_code[7:0]
	input  logic        s_tlast,   // last_char
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata    // value[63:0]
);
	import ilp_pkg::*;

	logic        valid_s1;
	logic [7:0]  char_s1;
	logic        last_s1;
	phase_t      phase_q;
	logic [63:0] acc_q;
	logic        out_valid_q;
	logic [63:0] value_q;
	logic        advance;
	logic        fire;
	step_t       nxt;

	// input stage moves unless a last character waits on a full output
	assign advance  = !valid_s1 || !last_s1 || !out_valid_q || m_tready;
	assign fire     = valid_s1 && advance;
	assign s_tready = advance;

	// character update
	ilp_step u_step (
		.phase     (phase_q),
		.acc       (acc_q),
		.char_code (char_s1),
		.nxt       (nxt)
	);

	// input stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= s_tvalid;
		end
	end

	// input stage payload
	always_ff @(posedge clk) begin
		if (advance && s_tvalid) begin
			char_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	// parser state, cleared after each string
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_START;
			acc_q   <= '0;
		end else if (fire) begin
			if (last_s1) begin
				phase_q <= PH_START;
				acc_q   <= '0;
			end else begin
				phase_q <= nxt.phase;
				acc_q   <= nxt.acc;
			end
		end
	end

	// output register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (fire && last_s1) begin
			value_q <= nxt.acc;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = value_q;

`ifndef SYNTH
	// a finished string shows its value and rearms the parser
	a_result_out: assert property (@(posedge clk) disable iff (!arst_n)
		fire && last_s1 |=> m_tvalid && (m_tdata == $past(nxt.acc))
			&& (phase_q == PH_START) && (acc_q == 64'd0))
		else $error("result not delivered or parser not rearmed");

	// no digits are held before a radix is chosen
	a_clear_acc: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_START) || (phase_q == PH_ZERO) |-> acc_q == 64'd0)
		else $error("accumulator not clear before radix");

	// an ended number ignores the rest of its string
	a_done_holds: assert property (@(posedge clk) disable iff (!arst_n)
		fire && !last_s1 && (phase_q == PH_DONE) |=> (phase_q == PH_DONE) && $stable(acc_q))
		else $error("ended number changed");
`endif

endmodule

[hdl/ilp_step.sv]
module ilp_step (
	input  ilp_pkg::phase_t       phase,
	input  logic [63:0]           acc,
	input  logic [7:0]            char_code,
	output ilp_pkg::step_t        nxt
);
	import ilp_pkg::*;

	logic        is_dec;
	logic        is_nz_dec;
	logic        is_oct;
	logic        is_lhex;
	logic        is_uhex;
	logic        is_x;
	logic [3:0]  hex_val;
	logic [63:0] acc_dec;
	logic [63:0] acc_hex;
	logic [63:0] acc_oct;
	logic [63:0] acc_sfx;

	// character classes
	assign is_dec    = (char_code >= CH_0) && (char_code <= CH_9);
	assign is_nz_dec = (char_code >= CH_1) && (char_code <= CH_9);
	assign is_oct    = (char_code >= CH_0) && (char_code <= CH_7);
	assign is_lhex   = (char_code >= CH_LA) && (char_code <= CH_LF);
	assign is_uhex   = (char_code >= CH_UA) && (char_code <= CH_UF);
	assign is_x      = (char_code == CH_LX) || (char_code == CH_UX);

	// letters a-f and A-F have 1..6 in the low bits
	assign hex_val = (is_lhex || is_uhex) ? ({1'b0, char_code[2:0]} + 4'd9) : char_code[3:0];

	// times ten as two shifts and an add, plus the digit
	assign acc_dec = {acc[60:0], 3'b000} + {acc[62:0], 1'b0} + {60'd0, char_code[3:0]};
	assign acc_hex = {acc[59:0], hex_val};
	assign acc_oct = {acc[60:0], char_code[2:0]};

	// binary suffix shift, anything else leaves the value as is
	always_comb begin
		priority if (char_code == CH_LK || char_code == CH_UK) begin
			acc_sfx = {acc[53:0], 10'd0};
		end else if (char_code == CH_LM || char_code == CH_UM) begin
			acc_sfx = {acc[43:0], 20'd0};
		end else if (char_code == CH_LG || char_code == CH_UG) begin
			acc_sfx = {acc[33:0], 30'd0};
		end else if (char_code == CH_LT || char_code == CH_UT) begin
			acc_sfx = {acc[23:0], 40'd0};
		end else begin
			acc_sfx = acc;
		end
	end

	// next phase and accumulator
	always_comb begin
		nxt.phase = phase;
		nxt.acc   = acc;
		unique case (phase)
			PH_START: begin
				if (is_nz_dec) begin
					nxt.acc   = {60'd0, char_code[3:0]};
					nxt.phase = PH_DEC;
				end else if (char_code == CH_0) begin
					nxt.phase = PH_ZERO;
				end else begin
					nxt.phase = PH_DONE;
				end
			end
			PH_ZERO: begin
				if (is_x) begin
					nxt.phase = PH_HEX;
				end else if (is_oct) begin
					nxt.phase = PH_OCT;
					nxt.acc   = acc_oct;
				end else begin
					nxt.phase = PH_DONE;
				end
			end
			PH_DEC: begin
				if (is_dec) begin
					nxt.acc = acc_dec;
				end else begin
					nxt.acc   = acc_sfx;
					nxt.phase = PH_DONE;
				end
			end
			PH_HEX: begin
				if (is_dec || is_lhex || is_uhex) begin
					nxt.acc = acc_hex;
				end else begin
					nxt.phase = PH_DONE;
				end
			end
			PH_OCT: begin
				if (is_oct) begin
					nxt.acc = acc_oct;
				end else begin
					nxt.phase = PH_DONE;
				end
			end
			default: begin
				nxt.phase = phase;
			end
		endcase
	end

endmodule
